// ===== rtl/core/pasm_pkg.sv =====
// Package for the polynomial add/subtract/multiply block: sizes, opcodes,
// microcode word layout and the microprogram ROM.
// No dependencies.
`timescale 1ns / 1ps

package pasm_pkg;

  localparam int MAX_TERMS = 32;
  localparam int IDX_W     = $clog2(MAX_TERMS);
  localparam int K_W       = IDX_W + 1;
  localparam int OP_W      = 3;
  localparam int TERM_W    = 5;
  localparam int COEF_W    = 16;
  localparam int RDEG_W    = 6;
  localparam int RCOEF_W   = 37;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int UA_W      = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_LOAD_A = 3'd1,
    OP_LOAD_B = 3'd2,
    OP_ADD    = 3'd3,
    OP_SUB    = 3'd4,
    OP_MUL    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    C_ALWAYS,
    C_LAST,
    C_IDONE,
    C_DISPATCH
  } cond_t;

  localparam logic [UA_W-1:0] UA_IDLE   = 3'd0;
  localparam logic [UA_W-1:0] UA_ADDSUB = 3'd1;
  localparam logic [UA_W-1:0] UA_ROW    = 3'd2;
  localparam logic [UA_W-1:0] UA_MAC    = 3'd3;
  localparam logic [UA_W-1:0] UA_DRAIN  = 3'd4;
  localparam logic [UA_W-1:0] UA_EMIT   = 3'd5;

  typedef struct packed {
    cond_t           cond;
    logic [UA_W-1:0] tgt_t;
    logic [UA_W-1:0] tgt_f;
    logic            idle;
    logic            emit;
    logic            emit_sum;
    logic            row_init;
    logic            mac;
    logic            drain;
  } uword_t;

  typedef struct packed {
    logic accept;
    logic is_addsub;
    logic is_mul;
    logic last;
    logic i_done;
    logic out_free;
  } seq_status_t;

  typedef struct packed {
    uword_t uw;
    logic   fire;
  } seq_ctrl_t;

  function automatic uword_t ucode(input logic [UA_W-1:0] addr);
    uword_t w;
    w = '{cond: C_DISPATCH, tgt_t: UA_IDLE, tgt_f: UA_IDLE, idle: 1'b1,
          emit: 1'b0, emit_sum: 1'b0, row_init: 1'b0, mac: 1'b0, drain: 1'b0};
    case (addr)
      UA_IDLE: begin
      end
      UA_ADDSUB: begin
        w.cond = C_LAST; w.tgt_t = UA_IDLE; w.tgt_f = UA_ADDSUB; w.idle = 1'b0;
        w.emit = 1'b1; w.emit_sum = 1'b1;
      end
      UA_ROW: begin
        w.cond = C_ALWAYS; w.tgt_t = UA_MAC; w.tgt_f = UA_MAC; w.idle = 1'b0;
        w.row_init = 1'b1;
      end
      UA_MAC: begin
        w.cond = C_IDONE; w.tgt_t = UA_DRAIN; w.tgt_f = UA_MAC; w.idle = 1'b0;
        w.mac = 1'b1;
      end
      UA_DRAIN: begin
        w.cond = C_ALWAYS; w.tgt_t = UA_EMIT; w.tgt_f = UA_EMIT; w.idle = 1'b0;
        w.drain = 1'b1;
      end
      UA_EMIT: begin
        w.cond = C_LAST; w.tgt_t = UA_IDLE; w.tgt_f = UA_ROW; w.idle = 1'b0;
        w.emit = 1'b1;
      end
      default: begin
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/pasm_seq.sv =====
// Microcode sequencer: step counter, microprogram ROM and jump logic.
// Depends on pasm_pkg.
`timescale 1ns / 1ps

module pasm_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pasm_pkg::seq_status_t st,
  output pasm_pkg::seq_ctrl_t  ctrl
);
  import pasm_pkg::*;

  logic [UA_W-1:0] upc_r;
  logic [UA_W-1:0] upc_nxt;
  uword_t          uw;
  logic            fire;

  assign uw   = ucode(upc_r);
  assign fire = !(uw.emit && !st.out_free);
  assign ctrl = '{uw: uw, fire: fire};

  always_comb begin
    upc_nxt = upc_r;
    if (fire) begin
      case (uw.cond)
        C_ALWAYS: upc_nxt = uw.tgt_t;
        C_LAST:   upc_nxt = st.last ? uw.tgt_t : uw.tgt_f;
        C_IDONE:  upc_nxt = st.i_done ? uw.tgt_t : uw.tgt_f;
        C_DISPATCH: begin
          if (st.accept && st.is_mul) begin
            upc_nxt = UA_ROW;
          end else if (st.accept && st.is_addsub) begin
            upc_nxt = UA_ADDSUB;
          end else begin
            upc_nxt = UA_IDLE;
          end
        end
        default:  upc_nxt = UA_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

// ===== rtl/core/polynomial_add_sub_mul.sv =====
// Polynomial add/subtract/multiply block: coefficient stores, MAC datapath
// and output register, controlled by the pasm_seq microcode sequencer.
// Depends on pasm_pkg and pasm_seq.
//
// Use: transactions enter on in_valid/in_ready carrying opcode, term_index and
// coefficient_in. Clear and loads complete in the accepting cycle; the block
// is ready again on the next cycle. Add and subtract emit one coefficient per
// cycle while the output register is free, degree 0 up to max(degree A,
// degree B), last_term on the top one. Multiply emits degree 0 up to dA+dB;
// each output degree runs a row setup step, one multiply-accumulate step per
// coefficient pair of that degree on the single 16x16 multiply-accumulate
// unit, a drain step and an emit step. in_ready is high only while no compute
// is running. Results sit in an output register; when out_ready is low the
// sequencer holds at its emit step until the register drains. Reset zeroes
// both stores and degrees, empties the output register and idles the sequencer.
`timescale 1ns / 1ps

module polynomial_add_sub_mul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pasm_pkg::OP_W-1:0]           in_opcode,
  input  logic [pasm_pkg::TERM_W-1:0]         in_term_index,
  input  logic signed [pasm_pkg::COEF_W-1:0]  in_coefficient_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [pasm_pkg::RDEG_W-1:0]         out_result_degree,
  output logic signed [pasm_pkg::RCOEF_W-1:0] out_result_coefficient,
  output logic                                out_last_term
);
  import pasm_pkg::*;

  logic signed [COEF_W-1:0]  store_a_r [MAX_TERMS];
  logic signed [COEF_W-1:0]  store_b_r [MAX_TERMS];
  logic [IDX_W-1:0]          deg_a_r, deg_b_r;
  logic [K_W-1:0]            k_r, top_r;
  logic [IDX_W-1:0]          i_r, hi_r;
  logic                      sub_r;
  logic signed [RCOEF_W-1:0] acc_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic                      pv_r;
  logic                      out_valid_r;
  logic [RDEG_W-1:0]         out_deg_r;
  logic signed [RCOEF_W-1:0] out_coef_r;
  logic                      out_last_r;

  seq_status_t st;
  seq_ctrl_t   ctrl;

  logic             accept, is_clear, is_load_a, is_load_b, load_ok;
  logic             last, out_free;
  logic [K_W-1:0]   j_full, lo_full;
  logic [IDX_W-1:0] j_idx, k_idx;
  logic [K_W-1:0]   top_as, top_mul, k_ext;
  logic signed [COEF_W:0]    a_k, b_k, sum_k;
  logic signed [RCOEF_W-1:0] emit_val;

  assign in_ready  = ctrl.uw.idle;
  assign accept    = in_valid && in_ready;
  assign is_clear  = (op_t'(in_opcode) == OP_CLEAR);
  assign is_load_a = (op_t'(in_opcode) == OP_LOAD_A);
  assign is_load_b = (op_t'(in_opcode) == OP_LOAD_B);
  assign load_ok   = (int'(in_term_index) < MAX_TERMS);

  assign last     = (k_r == top_r);
  assign out_free = !out_valid_r || out_ready;

  assign st = '{accept: accept,
                is_addsub: (op_t'(in_opcode) == OP_ADD) || (op_t'(in_opcode) == OP_SUB),
                is_mul: (op_t'(in_opcode) == OP_MUL),
                last: last,
                i_done: (i_r == hi_r),
                out_free: out_free};

  pasm_seq u_seq (
    .clk  (clk),
    .rst_n(rst_n),
    .st   (st),
    .ctrl (ctrl)
  );

  assign top_as  = {1'b0, (deg_a_r > deg_b_r) ? deg_a_r : deg_b_r};
  assign top_mul = {1'b0, deg_a_r} + {1'b0, deg_b_r};
  assign k_idx   = k_r[IDX_W-1:0];
  assign k_ext   = k_r;
  assign lo_full = (k_ext > {1'b0, deg_b_r}) ? (k_ext - {1'b0, deg_b_r}) : '0;
  assign j_full  = k_r - {1'b0, i_r};
  assign j_idx   = j_full[IDX_W-1:0];

  assign a_k   = (k_r <= {1'b0, deg_a_r}) ?
                 {store_a_r[k_idx][COEF_W-1], store_a_r[k_idx]} : '0;
  assign b_k   = (k_r <= {1'b0, deg_b_r}) ?
                 {store_b_r[k_idx][COEF_W-1], store_b_r[k_idx]} : '0;
  assign sum_k = sub_r ? (a_k - b_k) : (a_k + b_k);
  assign emit_val = ctrl.uw.emit_sum ? RCOEF_W'(sum_k) : acc_r;

  // coefficient stores and degrees
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && is_clear)) begin
      for (int n = 0; n < MAX_TERMS; n++) begin
        store_a_r[n] <= '0;
        store_b_r[n] <= '0;
      end
      deg_a_r <= '0;
      deg_b_r <= '0;
    end else if (accept && load_ok) begin
      if (is_load_a) begin
        store_a_r[in_term_index[IDX_W-1:0]] <= in_coefficient_in;
        if (in_term_index[IDX_W-1:0] > deg_a_r) begin
          deg_a_r <= in_term_index[IDX_W-1:0];
        end
      end else if (is_load_b) begin
        store_b_r[in_term_index[IDX_W-1:0]] <= in_coefficient_in;
        if (in_term_index[IDX_W-1:0] > deg_b_r) begin
          deg_b_r <= in_term_index[IDX_W-1:0];
        end
      end
    end
  end

  // MAC datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (ctrl.fire) begin
      if (accept) begin
        k_r   <= '0;
        sub_r <= (op_t'(in_opcode) == OP_SUB);
        top_r <= st.is_mul ? top_mul : top_as;
      end
      if (ctrl.uw.row_init) begin
        acc_r <= '0;
        pv_r  <= 1'b0;
        i_r   <= lo_full[IDX_W-1:0];
        hi_r  <= (k_r < {1'b0, deg_a_r}) ? k_idx : deg_a_r;
      end
      if (ctrl.uw.mac) begin
        prod_r <= store_a_r[i_r] * store_b_r[j_idx];
        pv_r   <= 1'b1;
        if (pv_r) begin
          acc_r <= acc_r + RCOEF_W'(prod_r);
        end
        i_r <= i_r + 1'b1;
      end
      if (ctrl.uw.drain) begin
        acc_r <= acc_r + RCOEF_W'(prod_r);
        pv_r  <= 1'b0;
      end
      if (ctrl.uw.emit) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fire && ctrl.uw.emit) begin
      out_valid_r <= 1'b1;
      out_deg_r   <= RDEG_W'(k_r);
      out_coef_r  <= emit_val;
      out_last_r  <= last;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_result_degree      = out_deg_r;
  assign out_result_coefficient = out_coef_r;
  assign out_last_term          = out_last_r;

endmodule
